[hdl/bdre_pkg.sv]
// ----------------------------------------------------------------------------
// bdre_pkg
// Types and constants shared by the byte difference run extractor.
// ----------------------------------------------------------------------------
package bdre_pkg;

    localparam int BYTE_W              = 8;
    localparam int POS_W               = 12;
    localparam int LEN_W               = 13;
    localparam int CNT_W               = 12;
    localparam int BLOCK_BYTES_MAX_DEF = 4096;
    localparam int LEN_FIELD_MAX       = (1 << LEN_W) - 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [BYTE_W-1:0] old_byte;
        logic [BYTE_W-1:0] new_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic             run_valid;
        logic [POS_W-1:0] run_offset;
        logic [LEN_W-1:0] run_length;
        logic             block_done;
        logic [CNT_W-1:0] run_count;
        logic [LEN_W-1:0] diff_bytes;
        logic             status;
    } t_result;

endpackage

[hdl/bdre_in_if.sv]
// ----------------------------------------------------------------------------
// bdre_in_if
// Byte pair channel: valid, ready and one old/new byte pair per transfer.
// ----------------------------------------------------------------------------
interface bdre_in_if;
    import bdre_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/bdre_out_if.sv]
// ----------------------------------------------------------------------------
// bdre_out_if
// Result channel: valid, ready and one run/block report per transfer.
// ----------------------------------------------------------------------------
interface bdre_out_if;
    import bdre_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/bdre_out_buf.sv]
// ----------------------------------------------------------------------------
// bdre_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module bdre_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bdre_pkg::t_result i_push_data,
    output logic              o_push_ready,
    bdre_out_if.source        o_out
);
    import bdre_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    pop;

    assign pop          = r_out_valid && o_out.ready;
    assign o_push_ready = !r_skid_valid;
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_push_data;
            end
        end else if (i_push) begin
            r_skid_data <= i_push_data;
        end
    end

endmodule

[hdl/byte_diff_run_extractor.sv]
// ----------------------------------------------------------------------------
// byte_diff_run_extractor
// Compares old and new block bytes pairwise and reports runs of differing
// bytes, with a block summary on the last pair.
//
//  channel  dir  payload                                    transfer
//  i_in     in   old_byte, new_byte, last_byte              valid & ready
//  o_out    out  run_valid, run_offset, run_length,         valid & ready
//                block_done, run_count, diff_bytes, status
//
// One pair per cycle unless the result buffer is full; the compare and
// counter update sit between the run state registers and the two-entry buffer.
// Each result is registered in the result buffer before it reaches o_out.
// Reset clears the run state and empties the buffer.
// i_in.ready falls only when both buffer entries hold results.
// ----------------------------------------------------------------------------
module byte_diff_run_extractor #(
    parameter int BLOCK_BYTES_MAX = bdre_pkg::BLOCK_BYTES_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdre_in_if.sink    i_in,
    bdre_out_if.source o_out
);
    import bdre_pkg::*;

    localparam int               LEN_CAP_I = (BLOCK_BYTES_MAX > LEN_FIELD_MAX) ?
                                             LEN_FIELD_MAX : BLOCK_BYTES_MAX;
    localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(LEN_CAP_I);

    logic             r_in_run;
    logic [POS_W-1:0] r_run_start;
    logic [LEN_W-1:0] r_run_len;
    logic [POS_W-1:0] r_position;
    logic [CNT_W-1:0] r_runs_seen;
    logic [LEN_W-1:0] r_bytes_seen;

    logic             accept;
    logic             push_ready;
    logic             differ;
    logic             last;
    logic             closed;
    logic             has_result;
    logic [LEN_W-1:0] len_inc;
    logic [LEN_W-1:0] n_run_len;
    logic [POS_W-1:0] n_run_start;
    logic [CNT_W-1:0] n_runs_seen;
    logic [LEN_W:0]   bytes_sum;
    logic [LEN_W-1:0] n_bytes_seen;
    t_result          result;

    assign i_in.ready = push_ready;
    assign accept     = i_in.valid && push_ready;
    assign differ     = i_in.data.old_byte != i_in.data.new_byte;
    assign last       = i_in.data.last_byte;
    assign closed     = (differ && last) || (!differ && r_in_run);
    assign has_result = closed || last;

    always_comb begin
        len_inc     = (r_run_len >= LEN_CAP) ? LEN_CAP : r_run_len + 1'b1;
        n_run_start = r_in_run ? r_run_start : r_position;
        if (!differ) begin
            n_run_len = r_run_len;
        end else if (!r_in_run) begin
            n_run_len = LEN_W'(1);
        end else begin
            n_run_len = len_inc;
        end
        n_runs_seen  = (r_runs_seen == CNT_MAX) ? CNT_MAX : r_runs_seen + 1'b1;
        bytes_sum    = {1'b0, r_bytes_seen} + {1'b0, n_run_len};
        n_bytes_seen = (bytes_sum > {1'b0, LEN_CAP}) ? LEN_CAP : bytes_sum[LEN_W-1:0];
    end

    always_comb begin
        result.run_valid  = closed;
        result.run_offset = closed ? n_run_start : '0;
        result.run_length = closed ? n_run_len : '0;
        result.block_done = last;
        result.run_count  = closed ? n_runs_seen : r_runs_seen;
        result.diff_bytes = closed ? n_bytes_seen : r_bytes_seen;
        result.status     = last && !closed && (r_runs_seen == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_position   <= '0;
            r_runs_seen  <= '0;
            r_bytes_seen <= '0;
        end else if (accept) begin
            if (last) begin
                r_in_run     <= 1'b0;
                r_run_start  <= '0;
                r_run_len    <= '0;
                r_position   <= '0;
                r_runs_seen  <= '0;
                r_bytes_seen <= '0;
            end else begin
                r_position <= r_position + 1'b1;
                if (closed) begin
                    r_in_run     <= 1'b0;
                    r_run_start  <= '0;
                    r_run_len    <= '0;
                    r_runs_seen  <= n_runs_seen;
                    r_bytes_seen <= n_bytes_seen;
                end else if (differ) begin
                    r_in_run    <= 1'b1;
                    r_run_start <= n_run_start;
                    r_run_len   <= n_run_len;
                end
            end
        end
    end

    bdre_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && has_result),
        .i_push_data (result),
        .o_push_ready(push_ready),
        .o_out       (o_out)
    );

endmodule

[hdl/bdre_checker.sv]
// ----------------------------------------------------------------------------
// bdre_checker
// Port-level checks on the run extractor, bound to the top level.
// ----------------------------------------------------------------------------
module bdre_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input bdre_pkg::t_result i_out_data
);
    import bdre_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // input stalls only with a result waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

    // a finished run has a length and is counted
    a_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.run_valid |->
            i_out_data.run_length != '0 && i_out_data.run_count != '0 &&
            i_out_data.diff_bytes != '0 && !i_out_data.status)
        else $error("inconsistent run report");

    // identical block reports no runs
    a_identical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status |->
            i_out_data.block_done && i_out_data.run_count == '0 &&
            i_out_data.diff_bytes == '0 && i_out_data.run_length == '0)
        else $error("identical block with runs");

endmodule

bind byte_diff_run_extractor bdre_checker u_bdre_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data (o_out.data)
);

[verif/tb_byte_diff_run_extractor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_diff_run_extractor
// Streams old/new byte pairs through the run extractor and checks every run
// and block report against an in-bench tracker of the run state. Covers
// single-pair blocks, runs closed by an equal pair and by the last pair,
// a long run, random blocks and long stalls.
// ----------------------------------------------------------------------------
module tb_byte_diff_run_extractor;
    import bdre_pkg::*;

    localparam int BLOCK_MAX    = BLOCK_BYTES_MAX_DEF;
    localparam int LEN_CAP      = (BLOCK_MAX > LEN_FIELD_MAX) ? LEN_FIELD_MAX : BLOCK_MAX;
    localparam int WAIT_MAX     = 18;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk;
    logic i_rst_n;

    bdre_in_if  in_if ();
    bdre_out_if out_if ();

    byte_diff_run_extractor #(
        .BLOCK_BYTES_MAX(BLOCK_MAX)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // run tracker state
    logic             trk_in_run;
    logic [POS_W-1:0] trk_run_start;
    logic [LEN_W-1:0] trk_run_len;
    logic [POS_W-1:0] trk_pos;
    logic [CNT_W-1:0] trk_runs;
    logic [LEN_W-1:0] trk_bytes;

    t_result run_reports_due[$];
    int      mismatches  = 0;
    int      cycle_count = 0;
    int      tx_max_wait = WAIT_MAX;
    int      rx_hold_req = 0;
    bit      tx_no_idle  = 1'b0;
    bit      rx_no_idle  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[byte_diff_run_extractor] ERROR");
            $finish;
        end
    end

    function automatic int draw_wait(input int max_wait, inout bit no_idle);
        if ($urandom_range(0, 99) < 4)
            no_idle = !no_idle;
        if (no_idle || max_wait == 0)
            return 0;
        return $urandom_range(0, max_wait);
    endfunction

    function automatic void clear_tracker();
        trk_in_run    = 1'b0;
        trk_run_start = '0;
        trk_run_len   = '0;
        trk_pos       = '0;
        trk_runs      = '0;
        trk_bytes     = '0;
    endfunction

    // Advance the run state by one accepted pair; queue the report it causes.
    function automatic void track_pair(input t_in_item pair);
        t_result     rep;
        logic        closed;
        int unsigned sum;
        rep    = '0;
        closed = 1'b0;
        if (pair.old_byte != pair.new_byte) begin
            if (!trk_in_run) begin
                trk_in_run    = 1'b1;
                trk_run_start = trk_pos;
                trk_run_len   = LEN_W'(1);
            end else if (trk_run_len < LEN_CAP) begin
                trk_run_len = trk_run_len + 1'b1;
            end
            closed = pair.last_byte;
        end else begin
            closed = trk_in_run;
        end
        if (closed) begin
            rep.run_valid  = 1'b1;
            rep.run_offset = trk_run_start;
            rep.run_length = trk_run_len;
            if (trk_runs != CNT_MAX)
                trk_runs = trk_runs + 1'b1;
            sum = int'(trk_bytes) + int'(trk_run_len);
            trk_bytes     = (sum > LEN_CAP) ? LEN_W'(LEN_CAP) : LEN_W'(sum);
            trk_in_run    = 1'b0;
            trk_run_start = '0;
            trk_run_len   = '0;
        end
        if (closed || pair.last_byte) begin
            rep.block_done = pair.last_byte;
            rep.run_count  = trk_runs;
            rep.diff_bytes = trk_bytes;
            rep.status     = pair.last_byte && (trk_runs == 0);
            run_reports_due.push_back(rep);
        end
        if (pair.last_byte)
            clear_tracker();
        else
            trk_pos = trk_pos + 1'b1;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    task automatic check_report(input t_result got);
        t_result want;
        if (run_reports_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected report, expected none, got %h", $time, got);
        end else begin
            want = run_reports_due.pop_front();
            check_field("run_valid",  want.run_valid,  got.run_valid);
            check_field("run_offset", want.run_offset, got.run_offset);
            check_field("run_length", want.run_length, got.run_length);
            check_field("block_done", want.block_done, got.block_done);
            check_field("run_count",  want.run_count,  got.run_count);
            check_field("diff_bytes", want.diff_bytes, got.diff_bytes);
            check_field("status",     want.status,     got.status);
        end
    endtask

    // result side: random stalls per transfer, plus long holds on request
    initial begin : report_sink
        int   stall;
        int   hold_left;
        logic rdy;
        stall     = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                check_report(out_if.data);
                stall = draw_wait(WAIT_MAX, rx_no_idle);
            end
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall > 0) begin
                stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_if.ready <= rdy;
        end
    end

    task automatic send_bytes(input logic [7:0] old_b, input logic [7:0] new_b,
                              input logic last_b);
        t_in_item pair;
        int       gap;
        pair = '{old_byte: old_b, new_byte: new_b, last_byte: last_b};
        gap  = draw_wait(tx_max_wait, tx_no_idle);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= pair;
        do @(posedge i_clk); while (!in_if.ready);
        track_pair(pair);
    endtask

    task automatic send_kind(input bit differ, input logic last_b);
        logic [7:0] old_b;
        old_b = 8'($urandom_range(0, 255));
        send_bytes(old_b, differ ? old_b ^ 8'($urandom_range(1, 255)) : old_b, last_b);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (run_reports_due.size() != 0);
    endtask

    task automatic test_single_pairs();
        send_bytes(8'h00, 8'h00, 1'b1);
        send_bytes(8'hFF, 8'hFF, 1'b1);
        send_bytes(8'hFF, 8'h00, 1'b1);
        send_bytes(8'h00, 8'hFF, 1'b1);
    endtask

    task automatic test_mixed_blocks();
        // run closed by an equal pair, then one closed by an equal last pair
        send_bytes(8'hA5, 8'h5A, 1'b0);
        send_bytes(8'h3C, 8'h3C, 1'b0);
        send_bytes(8'h01, 8'h02, 1'b0);
        send_bytes(8'h7E, 8'h7E, 1'b1);
        // run closed by a differing last pair
        send_bytes(8'h11, 8'h11, 1'b0);
        send_bytes(8'h22, 8'h23, 1'b0);
        send_bytes(8'h44, 8'h45, 1'b1);
        // identical block
        send_bytes(8'h80, 8'h80, 1'b0);
        send_bytes(8'h7F, 8'h7F, 1'b0);
        send_bytes(8'h55, 8'h55, 1'b1);
        // several runs, last pair equal and outside any run
        send_bytes(8'hF0, 8'h0F, 1'b0);
        send_bytes(8'hAA, 8'hAA, 1'b0);
        send_bytes(8'h00, 8'h80, 1'b0);
        send_bytes(8'h01, 8'h03, 1'b0);
        send_bytes(8'h99, 8'h99, 1'b0);
        send_bytes(8'h33, 8'h33, 1'b1);
    endtask

    task automatic test_long_run();
        // one long run closed by the last pair
        for (int i = 0; i < 48; i++)
            send_kind(1'b1, i == 47);
    endtask

    task automatic test_backpressure();
        rx_hold_req = 300;
        tx_max_wait = 0;
        for (int i = 0; i < 40; i++)
            send_kind(i % 2 == 0, i == 39);
        tx_max_wait = WAIT_MAX;
        wait_drained();
        for (int i = 0; i < 12; i++)
            send_kind(1'($urandom_range(0, 1)), i == 11);
    endtask

    task automatic test_random_blocks();
        int sent;
        int blk_len;
        int seg_left;
        bit noisy;
        bit differ;
        sent = 0;
        while (sent < 280) begin
            blk_len  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            noisy    = ($urandom_range(0, 4) == 0);
            differ   = 1'($urandom_range(0, 1));
            seg_left = $urandom_range(1, 5);
            for (int i = 0; i < blk_len; i++) begin
                if (noisy) begin
                    send_bytes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               i == blk_len - 1);
                end else begin
                    send_kind(differ, i == blk_len - 1);
                    seg_left--;
                    if (seg_left == 0) begin
                        differ   = !differ;
                        seg_left = $urandom_range(1, 5);
                    end
                end
                sent++;
            end
        end
    endtask

    initial begin
        clear_tracker();
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_pairs();
        test_mixed_blocks();
        test_long_run();
        test_backpressure();
        test_random_blocks();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && run_reports_due.size() == 0) begin
            $display("[byte_diff_run_extractor] OK");
        end else begin
            $display("[byte_diff_run_extractor] ERROR");
        end
        $finish;
    end

endmodule
